// ----- src/grsc_pkg.sv -----
// grsc_pkg: constants, shift and substitution tables, and shared types
// for the group reverse / shift / substitute cipher. No dependencies.
package grsc_pkg;

   localparam int GROUP_SIZE = 4;
   localparam int HELD_DEPTH = GROUP_SIZE - 1;
   localparam int ALPHA_LEN  = 26;
   localparam int CNT_W      = 2;   // held byte count, 0..HELD_DEPTH
   localparam int NUM_W      = 3;   // results in a group, 1..GROUP_SIZE
   localparam int POS_W      = 5;   // line position mod 26
   localparam int CHAR_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index (paddr[2]) of the mode register
   localparam logic CSR_IDX_DECRYPT_MODE = 1'b0;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [POS_W-1:0]  pos_type;

   // group assembled by the gather stage, input order
   typedef struct packed {
      logic [GROUP_SIZE-1:0][CHAR_W-1:0] bytes;
      logic [NUM_W-1:0]                  count;
      logic                              full;
      logic                              line_end;
      pos_type                           base_pos;
   } group_type;

   // transformed group, output order
   typedef struct packed {
      logic [GROUP_SIZE-1:0][CHAR_W-1:0] bytes;
      logic [NUM_W-1:0]                  count;
      logic                              line_end;
   } out_group_type;

   // (5*pos + 2) mod 26
   function automatic pos_type shift_of(input pos_type pos);
      pos_type r;
      case (pos)
         5'd0:  r = 5'd2;
         5'd1:  r = 5'd7;
         5'd2:  r = 5'd12;
         5'd3:  r = 5'd17;
         5'd4:  r = 5'd22;
         5'd5:  r = 5'd1;
         5'd6:  r = 5'd6;
         5'd7:  r = 5'd11;
         5'd8:  r = 5'd16;
         5'd9:  r = 5'd21;
         5'd10: r = 5'd0;
         5'd11: r = 5'd5;
         5'd12: r = 5'd10;
         5'd13: r = 5'd15;
         5'd14: r = 5'd20;
         5'd15: r = 5'd25;
         5'd16: r = 5'd4;
         5'd17: r = 5'd9;
         5'd18: r = 5'd14;
         5'd19: r = 5'd19;
         5'd20: r = 5'd24;
         5'd21: r = 5'd3;
         5'd22: r = 5'd8;
         5'd23: r = 5'd13;
         5'd24: r = 5'd18;
         5'd25: r = 5'd23;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // substitution alphabet, letter index in, letter index out
   function automatic pos_type subst_of(input pos_type idx);
      pos_type r;
      case (idx)
         5'd0:  r = 5'd23;  // x
         5'd1:  r = 5'd11;  // l
         5'd2:  r = 5'd17;  // r
         5'd3:  r = 5'd22;  // w
         5'd4:  r = 5'd16;  // q
         5'd5:  r = 5'd2;   // c
         5'd6:  r = 5'd9;   // j
         5'd7:  r = 5'd13;  // n
         5'd8:  r = 5'd12;  // m
         5'd9:  r = 5'd8;   // i
         5'd10: r = 5'd10;  // k
         5'd11: r = 5'd7;   // h
         5'd12: r = 5'd14;  // o
         5'd13: r = 5'd5;   // f
         5'd14: r = 5'd21;  // v
         5'd15: r = 5'd4;   // e
         5'd16: r = 5'd15;  // p
         5'd17: r = 5'd24;  // y
         5'd18: r = 5'd18;  // s
         5'd19: r = 5'd3;   // d
         5'd20: r = 5'd25;  // z
         5'd21: r = 5'd1;   // b
         5'd22: r = 5'd0;   // a
         5'd23: r = 5'd19;  // t
         5'd24: r = 5'd6;   // g
         5'd25: r = 5'd20;  // u
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // inverse alphabet
   function automatic pos_type inv_of(input pos_type idx);
      pos_type r;
      case (idx)
         5'd0:  r = 5'd22;
         5'd1:  r = 5'd21;
         5'd2:  r = 5'd5;
         5'd3:  r = 5'd19;
         5'd4:  r = 5'd15;
         5'd5:  r = 5'd13;
         5'd6:  r = 5'd24;
         5'd7:  r = 5'd11;
         5'd8:  r = 5'd9;
         5'd9:  r = 5'd6;
         5'd10: r = 5'd10;
         5'd11: r = 5'd1;
         5'd12: r = 5'd8;
         5'd13: r = 5'd7;
         5'd14: r = 5'd12;
         5'd15: r = 5'd16;
         5'd16: r = 5'd4;
         5'd17: r = 5'd2;
         5'd18: r = 5'd18;
         5'd19: r = 5'd23;
         5'd20: r = 5'd25;
         5'd21: r = 5'd14;
         5'd22: r = 5'd3;
         5'd23: r = 5'd0;
         5'd24: r = 5'd17;
         5'd25: r = 5'd20;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- src/grsc_gather.sv -----
// grsc_gather: holds raw bytes until a group completes or the line ends,
// tracks the line position of the group. Depends on grsc_pkg.
module grsc_gather (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  grsc_pkg::char_type  in_char,
   input  logic                in_last,
   output logic                emit,
   output grsc_pkg::group_type grp
);

   grsc_pkg::char_type                 held_ff [grsc_pkg::HELD_DEPTH];
   grsc_pkg::char_type                 held_in [grsc_pkg::HELD_DEPTH];
   logic [grsc_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   grsc_pkg::pos_type                  pos_ff, pos_in;
   logic [grsc_pkg::POS_W-1:0]         pos_step;

   assign emit = in_last || (cnt_ff == grsc_pkg::CNT_W'(grsc_pkg::HELD_DEPTH));

   always_comb begin
      for (int j = 0; j < grsc_pkg::HELD_DEPTH; j++) begin
         grp.bytes[j] = (grsc_pkg::CNT_W'(j) < cnt_ff) ? held_ff[j] : in_char;
      end
      grp.bytes[grsc_pkg::GROUP_SIZE-1] = in_char;
      grp.count    = grsc_pkg::NUM_W'(cnt_ff) + grsc_pkg::NUM_W'(1);
      grp.full     = (cnt_ff == grsc_pkg::CNT_W'(grsc_pkg::HELD_DEPTH));
      grp.line_end = in_last;
      grp.base_pos = pos_ff;
   end

   // next group starts GROUP_SIZE further on, mod 26
   always_comb begin
      pos_step = pos_ff + grsc_pkg::POS_W'(grsc_pkg::GROUP_SIZE);
      if (pos_step >= grsc_pkg::POS_W'(grsc_pkg::ALPHA_LEN)) begin
         pos_step = pos_step - grsc_pkg::POS_W'(grsc_pkg::ALPHA_LEN);
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      for (int j = 0; j < grsc_pkg::HELD_DEPTH; j++) begin
         held_in[j] = held_ff[j];
         if (accept && !emit && cnt_ff == grsc_pkg::CNT_W'(j)) begin
            held_in[j] = in_char;
         end
      end
      if (accept) begin
         if (emit) begin
            cnt_in = '0;
            pos_in = in_last ? '0 : pos_step;
         end else begin
            cnt_in = cnt_ff + grsc_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         pos_ff <= '0;
         for (int j = 0; j < grsc_pkg::HELD_DEPTH; j++) begin
            held_ff[j] <= '0;
         end
      end else begin
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
         for (int j = 0; j < grsc_pkg::HELD_DEPTH; j++) begin
            held_ff[j] <= held_in[j];
         end
      end
   end

endmodule

// ----- src/grsc_lane.sv -----
// grsc_lane: transforms one byte, shift then substitute (encrypt) or
// inverse substitute then inverse shift (decrypt). Depends on grsc_pkg.
module grsc_lane (
   input  grsc_pkg::char_type in_char,
   input  grsc_pkg::pos_type  pos,
   input  logic               dec,
   output grsc_pkg::char_type out_char
);

   logic                              letter;
   grsc_pkg::pos_type                 idx;
   grsc_pkg::pos_type                 sh;
   grsc_pkg::pos_type                 res;
   logic [grsc_pkg::POS_W:0]          sum;

   // 'A'..'Z' and 'a'..'z' have bits [7:6] = 01 and [4:0] in 1..26
   assign letter = (in_char[7:6] == 2'b01) && (in_char[4:0] != 5'd0)
                   && (in_char[4:0] <= grsc_pkg::POS_W'(grsc_pkg::ALPHA_LEN));
   assign idx    = in_char[4:0] - 5'd1;
   assign sh     = grsc_pkg::shift_of(pos);

   always_comb begin
      if (!dec) begin
         sum = {1'b0, idx} + {1'b0, sh};
      end else begin
         sum = {1'b0, grsc_pkg::inv_of(idx)}
               + (grsc_pkg::POS_W+1)'(grsc_pkg::ALPHA_LEN) - {1'b0, sh};
      end
      // sum is below 52, one subtract brings it into 0..25
      if (sum >= (grsc_pkg::POS_W+1)'(grsc_pkg::ALPHA_LEN)) begin
         sum = sum - (grsc_pkg::POS_W+1)'(grsc_pkg::ALPHA_LEN);
      end
      res = dec ? sum[grsc_pkg::POS_W-1:0] : grsc_pkg::subst_of(sum[grsc_pkg::POS_W-1:0]);
   end

   // case bit [5] kept
   assign out_char = letter ? {in_char[7:5], res + 5'd1} : in_char;

endmodule

// ----- src/grsc_serializer.sv -----
// grsc_serializer: result register holding one transformed group and
// shifting it out one byte per response. Depends on grsc_pkg.
module grsc_serializer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  grsc_pkg::out_group_type grp,
   output logic                    can_load,
   output logic                    out_valid,
   input  logic                    out_ready,
   output grsc_pkg::char_type      out_char,
   output logic                    out_line_end,
   output logic                    out_run_last
);

   logic [grsc_pkg::GROUP_SIZE-1:0][grsc_pkg::CHAR_W-1:0] bytes_ff, bytes_in;
   logic [grsc_pkg::NUM_W-1:0]                            rem_ff, rem_in;
   logic                                                  le_ff, le_in;
   logic                                                  last_one;
   logic                                                  pop;

   assign last_one     = (rem_ff == grsc_pkg::NUM_W'(1));
   assign out_valid    = (rem_ff != '0);
   assign pop          = out_valid && out_ready;
   assign can_load     = (rem_ff == '0) || (out_ready && last_one);
   assign out_char     = bytes_ff[0];
   assign out_run_last = last_one;
   assign out_line_end = le_ff && last_one;

   always_comb begin
      bytes_in = bytes_ff;
      rem_in   = rem_ff;
      le_in    = le_ff;
      if (load) begin
         bytes_in = grp.bytes;
         rem_in   = grp.count;
         le_in    = grp.line_end;
      end else if (pop) begin
         bytes_in = {grsc_pkg::CHAR_W'(0),
                     bytes_ff[grsc_pkg::GROUP_SIZE-1:1]};
         rem_in   = rem_ff - grsc_pkg::NUM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      le_ff    <= le_in;
   end

endmodule

// ----- src/group_reverse_shift_substitute_cipher.sv -----
// Top level of the group reverse / shift / substitute byte cipher.
// Depends on grsc_pkg, grsc_gather, grsc_lane, grsc_serializer.
//
//  port group | direction | contents
//  req_*      | in        | tdata[7:0] in_char, tlast line_end
//  rsp_*      | out       | tdata[7:0] out_char, tuser[0] out_line_end, tlast run_last
//  csr_*      | in/out    | APB, register 0 (addr 0x0): bit 0 decrypt_mode
//
// A request that only fills the group buffer is taken every cycle. A request
// that completes a group or ends the line is taken when the result register is
// empty or its last response leaves in the same cycle; its group is transformed
// in that cycle and the first response shows in the next cycle. Responses leave
// one per cycle, so the rate is one request per cycle whenever the response
// side keeps up (a short line end group can wait for the previous group to
// drain). Reset clears held count, line position and mode, and empties the
// result register. A response stall holds the result register and, once
// its group is pending, the next request that completes a group.
module group_reverse_shift_substitute_cipher (
   input  logic                                clock,
   input  logic                                reset,
   // requests
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] in_char
   input  logic                                req_tlast,   // line_end
   // responses
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // [7:0] out_char
   output logic [0:0]                          rsp_tuser,   // [0] out_line_end
   output logic                                rsp_tlast,   // run_last
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [grsc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [grsc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [grsc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic                     accept;
   logic                     emit;
   logic                     can_load;
   logic                     load;
   logic                     dec_ff, dec_in;
   logic                     csr_wr;
   grsc_pkg::group_type      grp;
   grsc_pkg::out_group_type  ogrp;
   grsc_pkg::char_type       lane_out [grsc_pkg::GROUP_SIZE];

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == grsc_pkg::CSR_IDX_DECRYPT_MODE);
   assign dec_in     = csr_wr ? csr_pwdata[0] : dec_ff;
   assign csr_prdata = (csr_paddr[2] == grsc_pkg::CSR_IDX_DECRYPT_MODE)
                       ? {(grsc_pkg::CSR_DATA_W-1)'(0), dec_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff <= 1'b0;
      end else begin
         dec_ff <= dec_in;
      end
   end

   // ---------------- request side ----------------
   // only a group-completing request needs room in the result register
   assign req_tready = !emit || can_load;
   assign accept     = req_tvalid && req_tready;
   assign load       = accept && emit;

   grsc_gather u_gather (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_char (req_tdata),
      .in_last (req_tlast),
      .emit    (emit),
      .grp     (grp)
   );

   // ---------------- transform lanes ----------------
   // lane j works on input byte j. Encrypt uses the output slot position
   // (reversed for a full group), decrypt the received position j.
   for (genvar j = 0; j < grsc_pkg::GROUP_SIZE; j++) begin : g_lane
      logic [1:0]        offs;
      grsc_pkg::pos_type psum;

      always_comb begin
         if (!dec_ff && grp.full) begin
            offs = 2'(grsc_pkg::GROUP_SIZE - 1 - j);
         end else begin
            offs = 2'(j);
         end
         psum = grp.base_pos + grsc_pkg::POS_W'(offs);
         if (psum >= grsc_pkg::POS_W'(grsc_pkg::ALPHA_LEN)) begin
            psum = psum - grsc_pkg::POS_W'(grsc_pkg::ALPHA_LEN);
         end
      end

      grsc_lane u_lane (
         .in_char  (grp.bytes[j]),
         .pos      (psum),
         .dec      (dec_ff),
         .out_char (lane_out[j])
      );
   end

   // full groups leave reversed, partial line-end groups in order
   always_comb begin
      for (int k = 0; k < grsc_pkg::GROUP_SIZE; k++) begin
         ogrp.bytes[k] = grp.full ? lane_out[grsc_pkg::GROUP_SIZE-1-k] : lane_out[k];
      end
      ogrp.count    = grp.count;
      ogrp.line_end = grp.line_end;
   end

   // ---------------- response side ----------------
   grsc_serializer u_ser (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .grp          (ogrp),
      .can_load     (can_load),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_char     (rsp_tdata),
      .out_line_end (rsp_tuser[0]),
      .out_run_last (rsp_tlast)
   );

endmodule

// ----- src/grsc_checker.sv -----
// grsc_checker: port-level assertions for the cipher top level, with the
// bind that attaches them. Depends on group_reverse_shift_substitute_cipher.
module grsc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                req_tlast,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [7:0]                          rsp_tdata,
   input logic [0:0]                          rsp_tuser,
   input logic                                rsp_tlast
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
      && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // line end response closes its run
   a_le_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("line end response without run_last");

   // a line end request produces a response in the next cycle
   a_le_resp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("no response after line end request");

   // a line end request only goes in while the result register frees up
   a_le_room: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast
      |-> !rsp_tvalid || (rsp_tready && rsp_tlast))
      else $error("line end request taken over a pending group");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind group_reverse_shift_substitute_cipher grsc_checker u_grsc_checker (.*);
